// ===== sv/acrs_pkg.sv =====
// Shared types, codes and AES helper functions for the AES counter random source.
package acrs_pkg;

   localparam logic [2:0] FUNC_WIDE     = 3'd0;
   localparam logic [2:0] FUNC_BYTE     = 3'd1;
   localparam logic [2:0] FUNC_BIT      = 3'd2;
   localparam logic [2:0] FUNC_PRIME    = 3'd3;
   localparam logic [2:0] FUNC_NONZERO  = 3'd4;
   localparam logic [2:0] FUNC_NOT_ONES = 3'd5;
   localparam logic [2:0] FUNC_BELOW    = 3'd6;
   localparam logic [2:0] FUNC_UNUSED   = 3'd7;

   localparam logic [1:0] POOL_WIDE = 2'd0;
   localparam logic [1:0] POOL_BYTE = 2'd1;
   localparam logic [1:0] POOL_BIT  = 2'd2;

   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_DRAW = 2'd1;
   localparam logic [1:0] SRC_REM  = 2'd2;

   localparam logic [8:0] MOD_MAX   = 9'd256;
   localparam logic [3:0] MOD_STEPS = 4'd8;
   localparam logic [3:0] LAST_ROUND = 4'd14;

   typedef struct packed {
      logic       fresh;
      logic       load;
      logic       take;
      logic       mod_start;
      logic       out_load;
      logic [1:0] pool;
      logic [1:0] out_src;
      logic [8:0] modulus;
   } acrs_cmd_type;

   typedef struct packed {
      logic pos_zero;
      logic aes_done;
      logic all_ones;
      logic mod_done;
      logic reject;
      logic rem_zero;
      logic out_free;
   } acrs_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[8*(i+4*c) +: 8] = SBOX[s[8*(i+4*((c+i)%4)) +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[8*(4*c)   +: 8];
         a1 = t[8*(4*c+1) +: 8];
         a2 = t[8*(4*c+2) +: 8];
         a3 = t[8*(4*c+3) +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return last ? t : m;
   endfunction

   function automatic logic [127:0] key_expand(input logic [127:0] ka, input logic [127:0] kb,
                                               input logic rot, input logic [7:0] rcon);
      logic [31:0]  w;
      logic [31:0]  x;
      logic [127:0] n;
      w = kb[127:96];
      if (rot) begin
         x = {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]] ^ rcon};
      end else begin
         x = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
      end
      n[31:0]   = ka[31:0]   ^ x;
      n[63:32]  = ka[63:32]  ^ n[31:0];
      n[95:64]  = ka[95:64]  ^ n[63:32];
      n[127:96] = ka[127:96] ^ n[95:64];
      return n;
   endfunction

endpackage

// ===== sv/acrs_aes.sv =====
// Iterative AES-256 encryption core, one round per cycle with on-the-fly key expansion.
module acrs_aes (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] din,
   input  logic [255:0] key,
   output logic         done,
   output logic [127:0] dout
);

   logic [127:0] s_ff, s_in;
   logic [127:0] ka_ff, ka_in;
   logic [127:0] kb_ff, kb_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   always_comb begin
      s_in     = s_ff;
      ka_in    = ka_ff;
      kb_in    = kb_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         s_in     = din ^ key[127:0];
         ka_in    = key[255:128];
         kb_in    = acrs_pkg::key_expand(key[127:0], key[255:128], 1'b1, 8'h01);
         rcon_in  = 8'h02;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         s_in     = acrs_pkg::aes_round(s_ff, round_ff == acrs_pkg::LAST_ROUND) ^ ka_ff;
         ka_in    = kb_ff;
         kb_in    = acrs_pkg::key_expand(ka_ff, kb_ff, !round_ff[0], rcon_ff);
         rcon_in  = round_ff[0] ? rcon_ff : acrs_pkg::xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == acrs_pkg::LAST_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      ka_ff    <= ka_in;
      kb_ff    <= kb_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign dout = s_ff;

endmodule

// ===== sv/acrs_datapath.sv =====
// Datapath: block counter, AES core, three pools, serial modulo unit and result register.
module acrs_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  acrs_pkg::acrs_cmd_type    cmd,
   output acrs_pkg::acrs_status_type status,
   input  logic [255:0]              key,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [63:0]               rsp_value
);

   logic [31:0]  counter_ff, counter_in;
   logic [127:0] wide_block_ff, byte_block_ff, bit_block_ff;
   logic         wide_pos_ff;
   logic [3:0]   byte_pos_ff;
   logic [6:0]   bit_pos_ff;
   logic [63:0]  draw_ff, draw_in;
   logic [7:0]   mb_ff;
   logic [7:0]   rem_ff, rem_in;
   logic [3:0]   mcnt_ff;
   logic         rsp_valid_ff;
   logic [63:0]  rsp_value_ff;
   logic         aes_done;
   logic [127:0] aes_dout;
   logic [8:0]   trial;
   logic [9:0]   span;

   assign counter_in = counter_ff + 32'd1;

   acrs_aes u_aes (
      .clock (clock),
      .reset (reset),
      .start (cmd.fresh),
      .din   ({counter_in, counter_in, counter_in, counter_in}),
      .key   (key),
      .done  (aes_done),
      .dout  (aes_dout)
   );

   always_comb begin
      draw_in = 64'd0;
      case (cmd.pool)
         acrs_pkg::POOL_WIDE: draw_in = wide_pos_ff ? wide_block_ff[63:0] : wide_block_ff[127:64];
         acrs_pkg::POOL_BYTE: draw_in = {56'd0, byte_block_ff[{byte_pos_ff, 3'd0} +: 8]};
         acrs_pkg::POOL_BIT:  draw_in = {63'd0, bit_block_ff[bit_pos_ff]};
         default:             draw_in = 64'd0;
      endcase
   end

   assign trial  = {rem_ff, mb_ff[7]};
   assign rem_in = (trial >= cmd.modulus) ? 8'(trial - cmd.modulus) : trial[7:0];
   assign span   = {2'd0, draw_ff[7:0]} - {2'd0, rem_ff} + {1'b0, cmd.modulus};

   always_ff @(posedge clock) begin
      if (cmd.load && cmd.pool == acrs_pkg::POOL_WIDE) wide_block_ff <= aes_dout;
      if (cmd.load && cmd.pool == acrs_pkg::POOL_BYTE) byte_block_ff <= aes_dout;
      if (cmd.load && cmd.pool == acrs_pkg::POOL_BIT)  bit_block_ff  <= aes_dout;
      if (cmd.take) draw_ff <= draw_in;
      if (cmd.mod_start) begin
         mb_ff  <= draw_ff[7:0];
         rem_ff <= 8'd0;
      end else if (mcnt_ff != 4'd0) begin
         mb_ff  <= {mb_ff[6:0], 1'b0};
         rem_ff <= rem_in;
      end
      if (cmd.out_load) begin
         case (cmd.out_src)
            acrs_pkg::SRC_DRAW: rsp_value_ff <= draw_ff;
            acrs_pkg::SRC_REM:  rsp_value_ff <= {56'd0, rem_ff};
            default:            rsp_value_ff <= 64'd0;
         endcase
      end
      if (reset) begin
         counter_ff   <= 32'hFFFF_FFFF;
         wide_pos_ff  <= 1'b0;
         byte_pos_ff  <= 4'd0;
         bit_pos_ff   <= 7'd0;
         mcnt_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.fresh) counter_ff <= counter_in;
         if (cmd.take && cmd.pool == acrs_pkg::POOL_WIDE) wide_pos_ff <= !wide_pos_ff;
         if (cmd.take && cmd.pool == acrs_pkg::POOL_BYTE) byte_pos_ff <= byte_pos_ff + 4'd1;
         if (cmd.take && cmd.pool == acrs_pkg::POOL_BIT)  bit_pos_ff  <= bit_pos_ff + 7'd1;
         if (cmd.mod_start) begin
            mcnt_ff <= acrs_pkg::MOD_STEPS;
         end else if (mcnt_ff != 4'd0) begin
            mcnt_ff <= mcnt_ff - 4'd1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.pos_zero = 1'b0;
      case (cmd.pool)
         acrs_pkg::POOL_WIDE: status.pos_zero = !wide_pos_ff;
         acrs_pkg::POOL_BYTE: status.pos_zero = byte_pos_ff == 4'd0;
         acrs_pkg::POOL_BIT:  status.pos_zero = bit_pos_ff == 7'd0;
         default:             status.pos_zero = 1'b0;
      endcase
      status.aes_done = aes_done;
      status.all_ones = &draw_ff;
      status.mod_done = mcnt_ff == 4'd0;
      status.reject   = span > {1'b0, acrs_pkg::MOD_MAX};
      status.rem_zero = rem_ff == 8'd0;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ===== sv/acrs_ctrl.sv =====
// Controller state machine that sequences pool refills, draws, rejection loops and results.
module acrs_ctrl #(
   parameter int PRIME_MODULUS = 67
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_func,
   input  logic [8:0]                req_modulus,
   output acrs_pkg::acrs_cmd_type    cmd,
   input  acrs_pkg::acrs_status_type status
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_AESWAIT  = 3'd2;
   localparam logic [2:0] ST_TAKE     = 3'd3;
   localparam logic [2:0] ST_CHECK    = 3'd4;
   localparam logic [2:0] ST_MOD      = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] func_ff, func_in;
   logic [8:0] mod_ff, mod_in;
   logic [1:0] src_ff, src_in;

   always_comb begin
      mod_in = req_modulus;
      if (req_modulus == 9'd0) begin
         mod_in = 9'd1;
      end else if (req_modulus > acrs_pkg::MOD_MAX) begin
         mod_in = acrs_pkg::MOD_MAX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      src_in        = src_ff;
      cmd           = '0;
      cmd.out_src   = src_ff;
      cmd.modulus   = (func_ff == acrs_pkg::FUNC_BELOW) ? mod_ff : 9'(PRIME_MODULUS);
      case (func_ff)
         acrs_pkg::FUNC_WIDE, acrs_pkg::FUNC_NOT_ONES: cmd.pool = acrs_pkg::POOL_WIDE;
         acrs_pkg::FUNC_BIT:                           cmd.pool = acrs_pkg::POOL_BIT;
         default:                                      cmd.pool = acrs_pkg::POOL_BYTE;
      endcase
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (func_ff == acrs_pkg::FUNC_UNUSED) begin
               src_in   = acrs_pkg::SRC_ZERO;
               state_in = ST_DONE;
            end else if (status.pos_zero) begin
               cmd.fresh = 1'b1;
               state_in  = ST_AESWAIT;
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_AESWAIT: begin
            if (status.aes_done) begin
               cmd.load = 1'b1;
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            cmd.take = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            unique case (func_ff) inside
               acrs_pkg::FUNC_WIDE, acrs_pkg::FUNC_BYTE, acrs_pkg::FUNC_BIT: begin
                  src_in   = acrs_pkg::SRC_DRAW;
                  state_in = ST_DONE;
               end
               acrs_pkg::FUNC_NOT_ONES: begin
                  if (status.all_ones) begin
                     state_in = ST_DISPATCH;
                  end else begin
                     src_in   = acrs_pkg::SRC_DRAW;
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  cmd.mod_start = 1'b1;
                  state_in      = ST_MOD;
               end
            endcase
         end
         ST_MOD: begin
            if (status.mod_done) begin
               if (status.reject ||
                   (func_ff == acrs_pkg::FUNC_NONZERO && status.rem_zero)) begin
                  state_in = ST_DISPATCH;
               end else begin
                  src_in   = acrs_pkg::SRC_REM;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      src_ff  <= src_in;
      if (state_ff == ST_IDLE && req_valid) mod_ff <= mod_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

// ===== sv/aes_counter_random_source.sv =====
// Top level of the AES-256 counter-mode random value source.
// Usage: each item on the req_ channel asks for one random value (req_func selects
// a 64-bit draw, byte draw, bit draw, residue mod the prime, nonzero residue,
// 64-bit value that is not all ones, or a value below req_modulus). Exactly one
// item comes back on the rsp_ channel with the value in rsp_value.
// The 256-bit key is written through the APB port as four 64-bit words at byte
// addresses 0, 8, 16 and 24; write it only while no item is in flight.
// A draw from a pool that still holds data passes the DISPATCH, TAKE, CHECK and
// DONE states, and rsp_valid rises in the same cycle that req_stall falls.
// A draw that needs a fresh block waits in AESWAIT for the iterative AES core,
// which runs one round per cycle. Residue and bounded requests then pass the
// bit-serial modulo unit for the drawn byte, and rejected draws repeat the loop.
// Throughput: one item at a time; req_stall is high while an item is in work.
// Reset sets the block counter to all ones and empties all three pools; the key
// reads as zero. When rsp_stall holds the result, it stays in the result
// register and the block can still accept and process the next item, stalling
// at the end until the register is free.
module aes_counter_random_source #(
   parameter int PRIME_MODULUS = 67
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [8:0]  req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic [3:0][63:0]          key_ff;
   acrs_pkg::acrs_cmd_type    cmd;
   acrs_pkg::acrs_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (psel && penable && pwrite) begin
         key_ff[paddr[4:3]] <= pwdata;
      end
   end

   assign prdata = key_ff[paddr[4:3]];
   assign pready = 1'b1;

   acrs_ctrl #(
      .PRIME_MODULUS (PRIME_MODULUS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_modulus (req_modulus),
      .cmd         (cmd),
      .status      (status)
   );

   acrs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .key       (key_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value)
   );

endmodule

// ===== sv/acrs_checker.sv =====
// Port-level assertion checker for the AES counter random source and its bind.
module acrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("Stalled result item changed or dropped.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Input not stalled while an item is in work.");

   a_reset_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_reset_req: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("Input stalled right after reset.");

endmodule

bind aes_counter_random_source acrs_checker u_acrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value)
);
